// ===== hdl/sfs_pkg.sv =====
// Package for the sphere face subdivision unit: widths, payload structs and
// the saturation helper shared by the pipeline modules.
// No dependencies.
package sfs_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int FRAC_BITS   = 14;

	localparam int NUM_VERTS   = 4;
	localparam int IN_W        = NUM_VERTS * 3 * COORD_WIDTH;
	localparam int OUT_DATA_W  = ((3 * COORD_WIDTH + 3 + 7) / 8) * 8;
	localparam int OUT_USER_W  = 4;

	// a corner is a sum of up to four vertices
	localparam int VEC_W   = COORD_WIDTH + 2;
	// scaled magnitudes have their leading one at bit MSB_TGT
	localparam int MSB_TGT = 29;
	localparam int MG_W    = MSB_TGT + 1;
	localparam int SH_W    = $clog2(MG_W);
	localparam int SQ_W    = 2 * MG_W;
	localparam int M_W     = SQ_W + 2;
	localparam int L_W     = M_W / 2;
	localparam int N_W     = MG_W + FRAC_BITS + 1;
	localparam int Q_W     = FRAC_BITS + 1;
	localparam int SUM_W   = COORD_WIDTH + 2;
	localparam int SAT_W   = SUM_W + Q_W;
	localparam int DIV3_SH  = SUM_W;
	localparam int DIV3_MUL = ((1 << DIV3_SH) + 2) / 3;

	localparam logic [2:0] NODES_TRI  = 3'd3;
	localparam logic [2:0] NODES_QUAD = 3'd4;
	localparam logic [2:0] LAST_SF_TRI  = 3'd5;
	localparam logic [2:0] LAST_SF_QUAD = 3'd3;

	typedef logic signed [VEC_W-1:0]       vec_t;
	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		logic [2:0] sub_face;
		logic [2:0] corner;
		logic       cent;
		logic       last;
		logic       quad;
	} meta_t;

	typedef struct packed {
		logic [2:0][MG_W-1:0] mg;
		logic [2:0]           sgn;
		logic                 zero;
		meta_t                meta;
	} npay_t;

	typedef struct packed {
		logic [2:0] sgn;
		logic       zero;
		meta_t      meta;
	} spay_t;

	function automatic coord_t sat_coord(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		coord_t                  r;
		hi = {{(SAT_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			r = hi[COORD_WIDTH-1:0];
		end else if (v < lo) begin
			r = lo[COORD_WIDTH-1:0];
		end else begin
			r = v[COORD_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/sfs_seq.sv =====
// Face register and corner sequencer: holds one face and issues one corner
// or centroid token per cycle into the pipeline while en is high. Depends on sfs_pkg.
module sfs_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       quad_mode,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [sfs_pkg::IN_W-1:0]   s_tdata,
	output logic                       tok_valid,
	output sfs_pkg::vec_t [2:0]        tok_vec,
	output sfs_pkg::meta_t             tok_meta
);
	import sfs_pkg::*;

	vec_t       v_q [NUM_VERTS][3];
	logic       busy_q;
	logic       quad_q;
	logic [2:0] sf_q;
	logic [2:0] cn_q;

	logic       tok_valid_s1;
	vec_t [2:0] vec_s1;
	meta_t      meta_s1;

	logic       at_cent;
	logic       last_step;
	logic       take;
	logic [2:0] nodes;
	logic [2:0] last_sf;
	logic [2:0] i0, i1, i2, sf2;
	vec_t       h [8][3];
	vec_t       ctr [3];
	vec_t       sel [3];

	always_comb begin
		nodes     = quad_q ? NODES_QUAD : NODES_TRI;
		last_sf   = quad_q ? LAST_SF_QUAD : LAST_SF_TRI;
		at_cent   = (cn_q == nodes);
		last_step = busy_q && at_cent && (sf_q == last_sf);
		s_tready  = en && (!busy_q || last_step);
		take      = s_tvalid && s_tready;
	end

	// ring of vertices and edge sums, then the corner picked for this step
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			h[0][j] = v_q[0][j];
			h[1][j] = v_q[0][j] + v_q[1][j];
			h[2][j] = v_q[1][j];
			h[3][j] = v_q[1][j] + v_q[2][j];
			h[4][j] = v_q[2][j];
			h[5][j] = quad_q ? (v_q[2][j] + v_q[3][j]) : (v_q[2][j] + v_q[0][j]);
			h[6][j] = v_q[3][j];
			h[7][j] = v_q[3][j] + v_q[0][j];
			ctr[j]  = v_q[0][j] + v_q[1][j] + v_q[2][j] + (quad_q ? v_q[3][j] : '0);
		end
		sf2 = {sf_q[1:0], 1'b0};
		i0  = quad_q ? (sf2 - 3'd1) : sf_q;
		i1  = quad_q ? sf2 : ((sf_q == LAST_SF_TRI) ? 3'd0 : (sf_q + 3'd1));
		i2  = sf2 + 3'd1;
		for (int j = 0; j < 3; j++) begin
			case (cn_q)
				3'd0: sel[j] = h[i0][j];
				3'd1: sel[j] = h[i1][j];
				3'd2: sel[j] = quad_q ? h[i2][j] : ctr[j];
				default: sel[j] = ctr[j];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			quad_q <= 1'b0;
			sf_q   <= '0;
			cn_q   <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			quad_q <= quad_mode;
			sf_q   <= '0;
			cn_q   <= '0;
		end else if (en && busy_q) begin
			if (last_step) begin
				busy_q <= 1'b0;
			end else if (at_cent) begin
				cn_q <= '0;
				sf_q <= sf_q + 3'd1;
			end else begin
				cn_q <= cn_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < NUM_VERTS; i++) begin
				for (int j = 0; j < 3; j++) begin
					v_q[i][j] <= vec_t'(signed'(s_tdata[(3*i+j)*COORD_WIDTH +: COORD_WIDTH]));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_s1 <= 1'b0;
		end else if (en) begin
			tok_valid_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en && busy_q) begin
			for (int j = 0; j < 3; j++) begin
				vec_s1[j] <= sel[j];
			end
			meta_s1 <= '{sub_face: sf_q, corner: cn_q, cent: at_cent, last: last_step,
				quad: quad_q};
		end
	end

	assign tok_valid = tok_valid_s1;
	assign tok_vec   = vec_s1;
	assign tok_meta  = meta_s1;

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> busy_q) else $error("face not held after take");
	a_ready_en: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> en) else $error("item taken while pipeline stalled");

endmodule

// ===== hdl/sfs_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, carrying the
// normalizer payload alongside. Depends on sfs_pkg.
module sfs_isqrt (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [sfs_pkg::M_W-1:0] in_m,
	input  sfs_pkg::npay_t          in_pay,
	output logic                    out_valid,
	output logic [sfs_pkg::L_W-1:0] out_root,
	output sfs_pkg::npay_t          out_pay
);
	import sfs_pkg::*;

	logic           v_s [1:L_W];
	logic [M_W-1:0] n_s [1:L_W];
	logic [M_W-1:0] r_s [1:L_W];
	npay_t          p_s [1:L_W];

	for (genvar j = 1; j <= L_W; j++) begin : g_stage
		localparam logic [M_W-1:0] B = {{(M_W-1){1'b0}}, 1'b1} << (2 * (L_W - j));
		logic           pv;
		logic [M_W-1:0] pn, pr, t;
		npay_t          pp;
		logic           ge;

		if (j == 1) begin : g_first
			assign pv = in_valid;
			assign pn = in_m;
			assign pr = '0;
			assign pp = in_pay;
		end else begin : g_next
			assign pv = v_s[j-1];
			assign pn = n_s[j-1];
			assign pr = r_s[j-1];
			assign pp = p_s[j-1];
		end

		assign t  = pr + B;
		assign ge = (pn >= t);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[j] <= ge ? (pn - t) : pn;
				r_s[j] <= ge ? ((pr >> 1) + B) : (pr >> 1);
				p_s[j] <= pp;
			end
		end
	end

	assign out_valid = v_s[L_W];
	assign out_root  = r_s[L_W][L_W-1:0];
	assign out_pay   = p_s[L_W];

endmodule

// ===== hdl/sfs_norm.sv =====
// Vector normalizer: scale, squares, sum, square root, restoring division
// and sign restore, all pipelined. Depends on sfs_pkg and sfs_isqrt.
module sfs_norm (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  sfs_pkg::vec_t [2:0]    in_vec,
	input  sfs_pkg::meta_t         in_meta,
	output logic                   out_valid,
	output sfs_pkg::coord_t [2:0]  out_p,
	output logic                   out_zero,
	output sfs_pkg::meta_t         out_meta
);
	import sfs_pkg::*;

	// scale stage
	logic [VEC_W-1:0] mag [3];
	logic [VEC_W-1:0] orv;
	logic [SH_W-1:0]  msb;
	logic [SH_W-1:0]  sh;
	npay_t            pay_a;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = in_vec[i][VEC_W-1] ? VEC_W'(-in_vec[i]) : VEC_W'(in_vec[i]);
		end
		orv = mag[0] | mag[1] | mag[2];
		msb = '0;
		for (int k = 0; k < VEC_W; k++) begin
			if (orv[k]) msb = SH_W'(k);
		end
		sh = SH_W'(MSB_TGT) - msb;
		for (int i = 0; i < 3; i++) begin
			pay_a.mg[i]  = MG_W'(mag[i]) << sh;
			pay_a.sgn[i] = in_vec[i][VEC_W-1];
		end
		pay_a.zero = (orv == '0);
		pay_a.meta = in_meta;
	end

	logic            v_s2, v_s3, v_s4;
	npay_t           pay_s2, pay_s3, pay_s4;
	logic [SQ_W-1:0] sq_s3 [3];
	logic [M_W-1:0]  m_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s2 <= pay_a;
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= pay_s2.mg[i] * pay_s2.mg[i];
			end
			pay_s3 <= pay_s2;
			m_s4   <= M_W'(sq_s3[0]) + M_W'(sq_s3[1]) + M_W'(sq_s3[2]);
			pay_s4 <= pay_s3;
		end
	end

	logic           rt_valid;
	logic [L_W-1:0] rt_root;
	npay_t          rt_pay;

	sfs_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.in_m     (m_s4),
		.in_pay   (pay_s4),
		.out_valid(rt_valid),
		.out_root (rt_root),
		.out_pay  (rt_pay)
	);

	// numerator with half the divisor added for rounding
	logic           v_s5;
	logic [N_W-1:0] n_s5 [3];
	logic [L_W-1:0] l_s5;
	spay_t          sp_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= rt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n_s5[i] <= (N_W'(rt_pay.mg[i]) << FRAC_BITS) + N_W'(rt_root >> 1);
			end
			l_s5  <= rt_root;
			sp_s5 <= '{sgn: rt_pay.sgn, zero: rt_pay.zero, meta: rt_pay.meta};
		end
	end

	// restoring division, one quotient bit per stage
	logic           dv_s [1:Q_W];
	logic [N_W-1:0] rem_s [1:Q_W][3];
	logic [Q_W-1:0] q_s [1:Q_W][3];
	logic [L_W-1:0] dl_s [1:Q_W];
	spay_t          dp_s [1:Q_W];

	for (genvar j = 1; j <= Q_W; j++) begin : g_div
		logic           pv;
		logic [N_W-1:0] prem [3];
		logic [Q_W-1:0] pq [3];
		logic [L_W-1:0] pl;
		spay_t          pp;
		logic [N_W-1:0] d;
		logic [N_W-1:0] nrem [3];
		logic [Q_W-1:0] nq [3];

		if (j == 1) begin : g_first
			assign pv = v_s5;
			assign pl = l_s5;
			assign pp = sp_s5;
			for (genvar i = 0; i < 3; i++) begin : g_c
				assign prem[i] = n_s5[i];
				assign pq[i]   = '0;
			end
		end else begin : g_next
			assign pv = dv_s[j-1];
			assign pl = dl_s[j-1];
			assign pp = dp_s[j-1];
			for (genvar i = 0; i < 3; i++) begin : g_c
				assign prem[i] = rem_s[j-1][i];
				assign pq[i]   = q_s[j-1][i];
			end
		end

		always_comb begin
			d = N_W'(pl) << (Q_W - j);
			for (int i = 0; i < 3; i++) begin
				nq[i] = pq[i];
				if (prem[i] >= d) begin
					nrem[i]        = prem[i] - d;
					nq[i][Q_W - j] = 1'b1;
				end else begin
					nrem[i] = prem[i];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j] <= 1'b0;
			end else if (en) begin
				dv_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					rem_s[j][i] <= nrem[i];
					q_s[j][i]   <= nq[i];
				end
				dl_s[j] <= pl;
				dp_s[j] <= pp;
			end
		end
	end

	// restore sign, saturate, force zero-length vectors to zero
	logic             v_s6;
	coord_t [2:0]     p_s6;
	logic             z_s6;
	meta_t            meta_s6;
	coord_t [2:0]     p_e;
	logic signed [SAT_W-1:0] qe [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qe[i] = {{(SAT_W-Q_W){1'b0}}, q_s[Q_W][i]};
			if (dp_s[Q_W].sgn[i]) qe[i] = -qe[i];
			p_e[i] = dp_s[Q_W].zero ? coord_t'(0) : sat_coord(qe[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= dv_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s6    <= p_e;
			z_s6    <= dp_s[Q_W].zero;
			meta_s6 <= dp_s[Q_W].meta;
		end
	end

	assign out_valid = v_s6;
	assign out_p     = p_s6;
	assign out_zero  = z_s6;
	assign out_meta  = meta_s6;

endmodule

// ===== hdl/sfs_cent.sv =====
// Centroid accumulator and output register: sums the normalized corners of
// a sub-face and forms their rounded mean. Depends on sfs_pkg.
module sfs_cent (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  sfs_pkg::coord_t [2:0]           in_p,
	input  logic                            in_zero,
	input  sfs_pkg::meta_t                  in_meta,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [sfs_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [sfs_pkg::OUT_USER_W-1:0]  m_tuser,
	output logic                            m_tlast
);
	import sfs_pkg::*;

	logic signed [SUM_W-1:0] sum_q [3];
	logic                    out_valid_q;
	coord_t [2:0]            p_q;
	logic [2:0]              sf_q;
	logic [2:0]              cn_q;
	logic                    zero_q;
	logic                    last_q;
	logic                    cent_q;
	logic                    quad_q;

	logic [SUM_W-1:0]          a [3];
	logic [2*SUM_W-1:0]        prod [3];
	logic [SUM_W-1:0]          q [3];
	logic signed [SAT_W-1:0]   qs [3];
	coord_t [2:0]              mean;
	coord_t [2:0]              p_sel;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a[i]    = sum_q[i][SUM_W-1] ? SUM_W'(-sum_q[i]) : SUM_W'(sum_q[i]);
			prod[i] = (2*SUM_W)'(a[i] + SUM_W'(1)) * (2*SUM_W)'(DIV3_MUL);
			q[i]    = in_meta.quad ? ((a[i] + SUM_W'(2)) >> 2) : prod[i][DIV3_SH +: SUM_W];
			qs[i]   = {{(SAT_W-SUM_W){1'b0}}, q[i]};
			if (sum_q[i][SUM_W-1]) qs[i] = -qs[i];
			mean[i]  = sat_coord(qs[i]);
			p_sel[i] = in_meta.cent ? mean[i] : in_p[i];
		end
	end

	// accumulate corners; restart on the first corner of each sub-face
	always_ff @(posedge clk) begin
		if (en && in_valid && !in_meta.cent) begin
			for (int i = 0; i < 3; i++) begin
				if (in_meta.corner == '0) begin
					sum_q[i] <= SUM_W'(in_p[i]);
				end else begin
					sum_q[i] <= sum_q[i] + SUM_W'(in_p[i]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			p_q    <= p_sel;
			sf_q   <= in_meta.sub_face;
			cn_q   <= in_meta.corner;
			zero_q <= in_meta.cent ? 1'b0 : in_zero;
			last_q <= in_meta.last;
			cent_q <= in_meta.cent;
			quad_q <= in_meta.quad;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({sf_q, p_q[2], p_q[1], p_q[0]});
	assign m_tuser  = {zero_q, cn_q};
	assign m_tlast  = last_q;

	a_last_cent: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> cent_q) else $error("last item is not a centroid");
	a_cent_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && cent_q) |-> !zero_q) else $error("centroid flagged zero length");
	a_cent_cn: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && cent_q) |-> (cn_q == (quad_q ? NODES_QUAD : NODES_TRI)))
		else $error("centroid corner number differs from node count");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))) else $error("item changed while held");

endmodule

// ===== hdl/sphere_face_subdivision_unit.sv =====
// Sphere face subdivision unit, top level.
// Depends on sfs_pkg, sfs_seq, sfs_norm (with sfs_isqrt) and sfs_cent.
//
// A face enters on the s_ channel: v0..v3 x,y,z, each signed 16 bits with 14
// fraction bits, v0_x in the lowest bits. In triangle mode v3 is ignored and
// the face yields six sub-triangles; in quad mode it yields four sub-quads.
// Each sub-face comes out on the m_ channel as its normalized corners and
// then the centroid of those corners, one point per item: 24 items for a
// triangle, 20 for a quad, m_tlast on the final one.
// quad_mode is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Throughput: one point per cycle unless m_tready holds the output; the corner
// sequencer takes the next face as it issues the last point of the current one.
// The 31-stage square root and 15-stage divider make up most of the pipeline.
// Reset clears all valid bits and sets triangle mode. When m_tready is low
// with an item waiting, the whole pipeline holds and s_tready drops; nothing
// is lost or repeated.
module sphere_face_subdivision_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,   // quad_mode
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// v0_x, v0_y, v0_z, v1_x, ... v3_z, 16 bits each
	input  logic [sfs_pkg::IN_W-1:0]        s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// px, py, pz, sub_face, zero fill
	output logic [sfs_pkg::OUT_DATA_W-1:0]  m_tdata,
	// corner, zero_length
	output logic [sfs_pkg::OUT_USER_W-1:0]  m_tuser,
	output logic                            m_tlast
);
	import sfs_pkg::*;

	logic          quad_mode_q;
	logic          en;
	logic          tok_valid;
	vec_t [2:0]    tok_vec;
	meta_t         tok_meta;
	logic          nv;
	coord_t [2:0]  np;
	logic          nz;
	meta_t         nmeta;

	// advance the whole pipeline unless the output item is held
	assign en = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_mode_q <= 1'b0;
		end else if (cfg_we) begin
			quad_mode_q <= cfg_wdata;
		end
	end

	sfs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.quad_mode(quad_mode_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.tok_valid(tok_valid),
		.tok_vec  (tok_vec),
		.tok_meta (tok_meta)
	);

	sfs_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (tok_valid),
		.in_vec   (tok_vec),
		.in_meta  (tok_meta),
		.out_valid(nv),
		.out_p    (np),
		.out_zero (nz),
		.out_meta (nmeta)
	);

	sfs_cent u_cent (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(nv),
		.in_p    (np),
		.in_zero (nz),
		.in_meta (nmeta),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for sphere_face_subdivision_unit: directed faces from a table,
// then random faces in both modes; each point is checked against a local predictor
// or, for all-zero faces, fixed zero points. Depends on sfs_pkg and the RTL of the unit.
module tb;
	import sfs_pkg::*;

	typedef struct packed {
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] pz;
		logic [2:0]  sf;
		logic [2:0]  cn;
		logic        zl;
		logic        lst;
	} point_t;

	typedef struct {
		bit                 quad;
		bit                 zero_face;
		logic signed [15:0] v [12];
	} face_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic                  cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  m_tlast;

	point_t pending_pts[$];
	bit     quad_sel;
	bit     quiet;
	bit     hold_req;
	int     errors;
	int     faces_sent;
	int     points_seen;

	sphere_face_subdivision_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("** sphere_face_subdivision_unit: FAILED **");
		$finish;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint clamp16(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// unit-length direction of c; returns 1 for a zero vector
	function automatic bit unit_dir(input longint c [3], output longint o [3]);
		longint unsigned mg [3];
		longint unsigned a;
		longint unsigned m;
		longint unsigned len;
		longint unsigned q;
		a = 0;
		m = 0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = c[i] < 0 ? -c[i] : c[i];
			if (mg[i] > a)
				a = mg[i];
		end
		if (a == 0) begin
			o[0] = 0; o[1] = 0; o[2] = 0;
			return 1;
		end
		while (a >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++)
				mg[i] >>= 1;
			a >>= 1;
		end
		while (a < (64'd1 << 29)) begin
			for (int i = 0; i < 3; i++)
				mg[i] <<= 1;
			a <<= 1;
		end
		for (int i = 0; i < 3; i++)
			m += mg[i] * mg[i];
		len = int_sqrt(m);
		for (int i = 0; i < 3; i++) begin
			q = ((mg[i] << FRAC_BITS) + len / 2) / len;
			o[i] = clamp16(c[i] < 0 ? -longint'(q) : longint'(q));
		end
		return 0;
	endfunction

	task automatic predict_face(input logic signed [15:0] v [12]);
		longint ring [8][3];
		longint ctr [3];
		longint crn [4][3];
		longint p [3];
		longint acc [3];
		longint a;
		int     n;
		int     nsub;
		bit     z;
		point_t e;
		n = quad_sel ? 4 : 3;
		nsub = quad_sel ? 4 : 6;
		ctr = '{0, 0, 0};
		for (int i = 0; i < n; i++)
			for (int j = 0; j < 3; j++) begin
				ring[2*i][j] = v[3*i+j];
				ctr[j] += v[3*i+j];
			end
		for (int i = 1; i < 2*n; i += 2)
			for (int j = 0; j < 3; j++)
				ring[i][j] = ring[i-1][j] + ring[(i+1) % (2*n)][j];
		for (int f = 0; f < nsub; f++) begin
			for (int j = 0; j < 3; j++) begin
				if (quad_sel) begin
					crn[0][j] = ring[(2*f+7) % 8][j];
					crn[1][j] = ring[2*f][j];
					crn[2][j] = ring[2*f+1][j];
					crn[3][j] = ctr[j];
				end else begin
					crn[0][j] = ring[f][j];
					crn[1][j] = ring[(f+1) % 6][j];
					crn[2][j] = ctr[j];
				end
			end
			acc = '{0, 0, 0};
			for (int i = 0; i < n; i++) begin
				z = unit_dir(crn[i], p);
				for (int j = 0; j < 3; j++)
					acc[j] += p[j];
				e = '{p[0][15:0], p[1][15:0], p[2][15:0], 3'(f), 3'(i), z, 1'b0};
				pending_pts.push_back(e);
			end
			// round to nearest, ties away from zero
			for (int j = 0; j < 3; j++) begin
				a = acc[j] < 0 ? -acc[j] : acc[j];
				a = (a + n / 2) / n;
				p[j] = clamp16(acc[j] < 0 ? -a : a);
			end
			e = '{p[0][15:0], p[1][15:0], p[2][15:0], 3'(f), 3'(n), 1'b0, f == nsub - 1};
			pending_pts.push_back(e);
		end
	endtask

	task automatic send_face(input logic signed [15:0] v [12]);
		logic [IN_W-1:0] d;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		for (int k = 0; k < 12; k++)
			d[16*k +: 16] = v[k];
		s_tdata <= d;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		faces_sent++;
	endtask

	// wait for the pipeline to empty, then write quad_mode
	task automatic set_mode(input bit m);
		s_tvalid <= 1'b0;
		while (pending_pts.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		cfg_wdata <= m;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		quad_sel = m;
	endtask

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sd0;
			3, 4: return $signed(16'($urandom_range(0, 511))) - 16'sd256;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic check_field(input string nm, input logic [15:0] exp_v, input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, nm, exp_v, act_v);
			errors++;
		end
	endtask

	// receiver: check accepted points, then choose next tready
	initial begin
		int idle_left;
		point_t e;
		idle_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				points_seen++;
				if (pending_pts.size() == 0) begin
					$display("%0t: unexpected point, got %h %h %b", $time, m_tdata, m_tuser,
						m_tlast);
					errors++;
				end else begin
					e = pending_pts.pop_front();
					check_field("px", e.px, m_tdata[15:0]);
					check_field("py", e.py, m_tdata[31:16]);
					check_field("pz", e.pz, m_tdata[47:32]);
					check_field("sub_face", 16'(e.sf), 16'(m_tdata[50:48]));
					check_field("corner", 16'(e.cn), 16'(m_tuser[2:0]));
					check_field("zero_length", 16'(e.zl), 16'(m_tuser[3]));
					check_field("last", 16'(e.lst), 16'(m_tlast));
				end
			end
			if (hold_req) begin
				hold_req = 0;
				idle_left = 300;
			end
			if (idle_left > 0) begin
				idle_left--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				idle_left = $urandom_range(0, 3);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		face_row_t          dir_tab [12];
		logic signed [15:0] v [12];
		point_t             e;
		int                 n;
		errors = 0;
		faces_sent = 0;
		points_seen = 0;
		quad_sel = 0;
		quiet = 0;
		hold_req = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;

		dir_tab[0]  = '{0, 1, '{12{16'sd0}}};
		dir_tab[1]  = '{0, 0, '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 0, 0, 0}};
		dir_tab[2]  = '{0, 0, '{32767, 32767, 32767, -32768, -32768, -32768,
			32767, -32768, 0, 16'sh8000, 16'sh7fff, 1}};
		// opposite vertices: zero-length edge point
		dir_tab[3]  = '{0, 0, '{1000, -200, 30, -1000, 200, -30, 5, 6, 7, 1, 2, 3}};
		dir_tab[4]  = '{0, 0, '{-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768, 0, 0, 0}};
		dir_tab[5]  = '{0, 0, '{1, 0, 0, 0, 1, 0, 0, 0, -1, 0, 0, 0}};
		dir_tab[6]  = '{1, 1, '{12{16'sd0}}};
		dir_tab[7]  = '{1, 0, '{16384, 16384, 16384, -16384, 16384, 16384,
			-16384, -16384, 16384, 16384, -16384, 16384}};
		dir_tab[8]  = '{1, 0, '{32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767, 32767, 32767, 32767, 32767}};
		// centre cancels to zero
		dir_tab[9]  = '{1, 0, '{500, 0, 0, 0, 500, 0, -500, 0, 0, 0, -500, 0}};
		dir_tab[10] = '{1, 0, '{-32768, 0, 32767, 0, -32768, 0, 32767, 0, -32768,
			1, -1, 1}};
		dir_tab[11] = '{1, 0, '{0, 0, 1, 0, 0, 1, 0, 0, 1, 0, 0, 1}};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_mode(0);

		foreach (dir_tab[r]) begin
			if (dir_tab[r].quad != quad_sel)
				set_mode(dir_tab[r].quad);
			send_face(dir_tab[r].v);
			if (dir_tab[r].zero_face) begin
				// all corners degenerate: zero points, flag on corners only
				n = quad_sel ? 4 : 3;
				for (int f = 0; f < (quad_sel ? 4 : 6); f++)
					for (int i = 0; i <= n; i++) begin
						e = '{16'h0, 16'h0, 16'h0, 3'(f), 3'(i), i != n,
							i == n && f == (quad_sel ? 3 : 5)};
						pending_pts.push_back(e);
					end
			end else begin
				predict_face(dir_tab[r].v);
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			set_mode(ph % 2 == 0);
			if (ph == 1)
				hold_req = 1;
			if (ph == 3)
				quiet = 1;
			for (int k = 0; k < 30; k++) begin
				foreach (v[i])
					v[i] = rand_coord();
				send_face(v);
				predict_face(v);
			end
		end
		s_tvalid <= 1'b0;

		while (pending_pts.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Ran %0d faces in triangle and quad mode, %0d points checked,", faces_sent,
			points_seen);
		$display("including degenerate, saturating and back-pressure cases.");
		if (errors == 0 && pending_pts.size() == 0) begin
			$display("** sphere_face_subdivision_unit: PASSED **");
		end else begin
			$display("** sphere_face_subdivision_unit: FAILED **");
		end
		$finish;
	end

endmodule
